[rtl/cld_pkg.sv]
// Shared types, constants and a hex-digit helper for the checksummed line deframer.
`default_nettype none

package cld_pkg;

    localparam int LINE_LIMIT = 160;
    localparam logic [7:0] LEN_CAP = 8'(LINE_LIMIT - 1);

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_FORMAT   = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] body_length;
        logic [7:0] computed_checksum;
        logic [7:0] received_checksum;
    } cld_verdict_t;

    // Bit 4 set marks a byte that is not a hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h41 + 8'd10);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/cld_check.sv]
// Line verdict: form check, hex decode and body checksum compare.
`default_nettype none

module cld_check
    import cld_pkg::*;
(
    input  wire logic [7:0]   line_count,
    input  wire logic [7:0]   running_xor,
    input  wire logic [7:0]   tail0,
    input  wire logic [7:0]   tail1,
    input  wire logic [7:0]   tail2,
    output cld_verdict_t      verdict
);

    logic [4:0] hi;
    logic [4:0] lo;
    logic       form_ok;
    logic [7:0] body_xor;
    logic [7:0] want;

    always_comb
    begin
        hi       = hex_nibble(tail1);
        lo       = hex_nibble(tail2);
        form_ok  = (line_count >= 8'd4) && (tail0 == CH_STAR) && !hi[4] && !lo[4];
        body_xor = running_xor ^ tail0 ^ tail1 ^ tail2;
        want     = {hi[3:0], lo[3:0]};
        if (!form_ok) begin
            verdict.status            = ST_FORMAT;
            verdict.body_length       = 8'd0;
            verdict.computed_checksum = 8'd0;
            verdict.received_checksum = 8'd0;
        end
        else begin
            verdict.status            = (body_xor == want) ? ST_GOOD : ST_CHECKSUM;
            verdict.body_length       = line_count - 8'd3;
            verdict.computed_checksum = body_xor;
            verdict.received_checksum = want;
        end
    end

endmodule

`default_nettype wire

[rtl/checksummed_line_deframer_core.sv]
// Checksummed line deframer top level: byte register, line state and verdict register.
// An accepted byte is held in the byte register; its verdict is registered when that byte advances.
// Throughput: one byte per cycle; a stalled verdict holds only a byte that ends or overflows a line.
// The byte register sits ahead of the verdict register, so a byte is taken while a verdict waits.
// Reset (rst_n low, asynchronous) clears the line state, the four counters and both valids.
`default_nettype none

module checksummed_line_deframer_core
    import cld_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [7:0]       body_length,
    output logic [7:0]       computed_checksum,
    output logic [7:0]       received_checksum,
    output logic [31:0]      good_lines,
    output logic [31:0]      format_errors,
    output logic [31:0]      checksum_errors,
    output logic [31:0]      overflow_errors
);

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  line_count_reg, line_count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  tail0_reg, tail0_next;
    logic [7:0]  tail1_reg, tail1_next;
    logic [7:0]  tail2_reg, tail2_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] format_reg, format_next;
    logic [31:0] checksum_reg, checksum_next;
    logic [31:0] overflow_reg, overflow_next;
    logic        out_valid_reg;
    cld_verdict_t result_reg, result_next;

    cld_verdict_t line_verdict;
    logic         is_term;
    logic         has_result;
    logic         advance;

    cld_check u_check (
        .line_count  (line_count_reg),
        .running_xor (xor_reg),
        .tail0       (tail0_reg),
        .tail1       (tail1_reg),
        .tail2       (tail2_reg),
        .verdict     (line_verdict)
    );

    always_comb
    begin
        is_term         = (byte_reg == CH_LF) || (byte_reg == CH_CR);
        has_result      = 1'b0;
        result_next     = line_verdict;
        line_count_next = line_count_reg;
        xor_next        = xor_reg;
        tail0_next      = tail0_reg;
        tail1_next      = tail1_reg;
        tail2_next      = tail2_reg;
        good_next       = good_reg;
        format_next     = format_reg;
        checksum_next   = checksum_reg;
        overflow_next   = overflow_reg;
        priority if (is_term) begin
            if (line_count_reg != 8'd0) begin
                has_result = 1'b1;
                unique case (line_verdict.status)
                    ST_GOOD:     good_next     = good_reg + 32'd1;
                    ST_FORMAT:   format_next   = format_reg + 32'd1;
                    ST_CHECKSUM: checksum_next = checksum_reg + 32'd1;
                    default:     overflow_next = overflow_reg;
                endcase
            end
        end
        else if (line_count_reg < LEN_CAP) begin
            line_count_next = line_count_reg + 8'd1;
            xor_next        = xor_reg ^ byte_reg;
            tail0_next      = tail1_reg;
            tail1_next      = tail2_reg;
            tail2_next      = byte_reg;
        end
        else begin
            has_result                    = 1'b1;
            overflow_next                 = overflow_reg + 32'd1;
            result_next.status            = ST_OVERFLOW;
            result_next.body_length       = 8'd0;
            result_next.computed_checksum = 8'd0;
            result_next.received_checksum = 8'd0;
        end
        // Clear the line after any verdict.
        if (has_result) begin
            line_count_next = 8'd0;
            xor_next        = 8'd0;
            tail0_next      = 8'd0;
            tail1_next      = 8'd0;
            tail2_next      = 8'd0;
        end
    end

    assign advance  = byte_valid_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready = !byte_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            line_count_reg <= 8'd0;
            xor_reg        <= 8'd0;
            tail0_reg      <= 8'd0;
            tail1_reg      <= 8'd0;
            tail2_reg      <= 8'd0;
            good_reg       <= 32'd0;
            format_reg     <= 32'd0;
            checksum_reg   <= 32'd0;
            overflow_reg   <= 32'd0;
        end
        else begin
            if (in_ready) begin
                byte_valid_reg <= in_valid;
            end
            if (advance) begin
                line_count_reg <= line_count_next;
                xor_reg        <= xor_next;
                tail0_reg      <= tail0_next;
                tail1_reg      <= tail1_next;
                tail2_reg      <= tail2_next;
                good_reg       <= good_next;
                format_reg     <= format_next;
                checksum_reg   <= checksum_next;
                overflow_reg   <= overflow_next;
            end
            if (advance && has_result) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on accept and on a new verdict.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            byte_reg <= rx_byte;
        end
        if (advance && has_result) begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = result_reg.status;
    assign body_length       = result_reg.body_length;
    assign computed_checksum = result_reg.computed_checksum;
    assign received_checksum = result_reg.received_checksum;
    assign good_lines        = good_reg;
    assign format_errors     = format_reg;
    assign checksum_errors   = checksum_reg;
    assign overflow_errors   = overflow_reg;

endmodule

`default_nettype wire

[verif/cld_verdict_monitor.sv]
`timescale 1ns / 1ps
// Verdict monitor: predicts each line verdict from accepted bytes and compares the outputs.
module cld_verdict_monitor
    import cld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [7:0]  body_length,
    input  logic [7:0]  computed_checksum,
    input  logic [7:0]  received_checksum,
    input  logic [31:0] good_lines,
    input  logic [31:0] format_errors,
    input  logic [31:0] checksum_errors,
    input  logic [31:0] overflow_errors,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  body_length;
        logic [7:0]  computed_checksum;
        logic [7:0]  received_checksum;
        logic [31:0] good_lines;
        logic [31:0] format_errors;
        logic [31:0] checksum_errors;
        logic [31:0] overflow_errors;
    } line_verdict_t;

    logic [7:0]  line_len;
    logic [7:0]  run_xor;
    logic [7:0]  tail [3];
    logic [31:0] n_good;
    logic [31:0] n_format;
    logic [31:0] n_checksum;
    logic [31:0] n_overflow;

    line_verdict_t verdicts_due [$];

    function automatic void clear_line();
        line_len = 8'd0;
        run_xor = 8'd0;
        tail[0] = 8'd0;
        tail[1] = 8'd0;
        tail[2] = 8'd0;
    endfunction

    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
            return 1'b1;
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic deframe_byte(input logic [7:0] b, output line_verdict_t v);
        logic       hi_ok;
        logic       lo_ok;
        logic [3:0] hi;
        logic [3:0] lo;
        logic [7:0] body_sum;
        v = '0;
        if (b == CH_CR || b == CH_LF)
        begin
            if (line_len == 8'd0)
            begin
                return 1'b0;
            end
            hi_ok = hex_digit(tail[1], hi);
            lo_ok = hex_digit(tail[2], lo);
            if (line_len < 8'd4 || tail[0] != CH_STAR || !hi_ok || !lo_ok)
            begin
                n_format = n_format + 32'd1;
                v.status = ST_FORMAT;
            end
            else
            begin
                body_sum = run_xor ^ tail[0] ^ tail[1] ^ tail[2];
                v.body_length = line_len - 8'd3;
                v.computed_checksum = body_sum;
                v.received_checksum = {hi, lo};
                if (body_sum != {hi, lo})
                begin
                    n_checksum = n_checksum + 32'd1;
                    v.status = ST_CHECKSUM;
                end
                else
                begin
                    n_good = n_good + 32'd1;
                    v.status = ST_GOOD;
                end
            end
        end
        else if (line_len < LEN_CAP)
        begin
            line_len = line_len + 8'd1;
            run_xor = run_xor ^ b;
            tail[0] = tail[1];
            tail[1] = tail[2];
            tail[2] = b;
            return 1'b0;
        end
        else
        begin
            n_overflow = n_overflow + 32'd1;
            v.status = ST_OVERFLOW;
        end
        clear_line();
        v.good_lines = n_good;
        v.format_errors = n_format;
        v.checksum_errors = n_checksum;
        v.overflow_errors = n_overflow;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        mismatches = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        line_verdict_t due;
        line_verdict_t fresh;
        logic          produced;
        if (!rst_n)
        begin
            clear_line();
            n_good = 32'd0;
            n_format = 32'd0;
            n_checksum = 32'd0;
            n_overflow = 32'd0;
            verdicts_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("verdict with none due: status %0d", status);
                    mismatches++;
                end
                else
                begin
                    due = verdicts_due.pop_front();
                    check_field("status", 32'(due.status), 32'(status));
                    check_field("body_length", 32'(due.body_length), 32'(body_length));
                    check_field("computed_checksum", 32'(due.computed_checksum),
                                32'(computed_checksum));
                    check_field("received_checksum", 32'(due.received_checksum),
                                32'(received_checksum));
                    check_field("good_lines", due.good_lines, good_lines);
                    check_field("format_errors", due.format_errors, format_errors);
                    check_field("checksum_errors", due.checksum_errors, checksum_errors);
                    check_field("overflow_errors", due.overflow_errors, overflow_errors);
                end
            end
            if (in_valid && in_ready)
            begin
                produced = deframe_byte(rx_byte, fresh);
                if (produced)
                begin
                    verdicts_due.push_back(fresh);
                end
            end
        end
        pending = verdicts_due.size();
    end

endmodule

[verif/checksummed_line_deframer_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top: drives framed and broken lines with idling and stalls, and reports the verdict.
module checksummed_line_deframer_core_tb;
    import cld_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RUN_BYTES   = 650;
    localparam int QUIET_AFTER = 560;

    typedef enum int {
        LINE_GOOD,
        LINE_MISMATCH,
        LINE_NO_STAR,
        LINE_BAD_DIGIT,
        LINE_SHORT,
        LINE_NOISE
    } line_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [7:0]  body_length;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
    logic [31:0] good_lines;
    logic [31:0] format_errors;
    logic [31:0] checksum_errors;
    logic [31:0] overflow_errors;

    int mismatches;
    int pending;
    int sent_bytes = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit long_hold = 1'b0;

    logic [7:0] line_q [$];

    checksummed_line_deframer_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .body_length       (body_length),
        .computed_checksum (computed_checksum),
        .received_checksum (received_checksum),
        .good_lines        (good_lines),
        .format_errors     (format_errors),
        .checksum_errors   (checksum_errors),
        .overflow_errors   (overflow_errors)
    );

    cld_verdict_monitor verdict_mon (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .body_length       (body_length),
        .computed_checksum (computed_checksum),
        .received_checksum (received_checksum),
        .good_lines        (good_lines),
        .format_errors     (format_errors),
        .checksum_errors   (checksum_errors),
        .overflow_errors   (overflow_errors),
        .mismatches        (mismatches),
        .pending           (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("checksummed_line_deframer_core_tb failed");
            $finish;
        end
    end

    always
    begin
        @(negedge clk);
        if (long_hold)
        begin
            out_ready = 1'b0;
            repeat (199) @(negedge clk);
            long_hold = 1'b0;
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            out_ready = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            rx_byte = 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte = b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sent_bytes++;
        if (sent_bytes > QUIET_AFTER)
        begin
            quiet = 1'b1;
        end
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == CH_CR || b == CH_LF)
        begin
            b = 8'($urandom);
        end
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic upper;
        upper = 1'($urandom);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (upper ? 8'h37 : 8'h57) + 8'(n);
    endfunction

    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 8))
            0: return 8'h3A;
            1: return 8'h40;
            2: return 8'h47;
            3: return 8'h67;
            4: return 8'h2F;
            5: return 8'h60;
            6: return 8'h00;
            7: return 8'hFF;
            default: return CH_STAR;
        endcase
    endfunction

    task automatic add_framed(input int body_len, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        repeat (body_len)
        begin
            b = body_byte();
            line_q.push_back(b);
            sum = sum ^ b;
        end
        if (corrupt)
        begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        line_q.push_back(CH_STAR);
        line_q.push_back(hex_char(sum[7:4]));
        line_q.push_back(hex_char(sum[3:0]));
    endtask

    task automatic drive_line(input line_kind_t kind);
        logic [7:0] b;
        case (kind)
            LINE_GOOD: add_framed($urandom_range(0, 12), 1'b0);
            LINE_MISMATCH: add_framed($urandom_range(1, 12), 1'b1);
            LINE_NO_STAR:
            begin
                add_framed($urandom_range(1, 12), 1'b0);
                b = body_byte();
                while (b == CH_STAR)
                begin
                    b = body_byte();
                end
                line_q[line_q.size() - 3] = b;
            end
            LINE_BAD_DIGIT:
            begin
                add_framed($urandom_range(1, 12), 1'b0);
                line_q[line_q.size() - $urandom_range(1, 2)] = non_hex_char();
            end
            LINE_SHORT:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    line_q.push_back(body_byte());
                end
            end
            default:
            begin
                repeat ($urandom_range(1, 10))
                begin
                    line_q.push_back(8'($urandom));
                end
            end
        endcase
        line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        if ($urandom_range(0, 3) == 0)
        begin
            line_q.push_back(CH_LF);
        end
        while (line_q.size() > 0)
        begin
            send_byte(line_q.pop_front());
        end
    endtask

    initial
    begin
        logic [7:0] opening [31] = '{
            CH_CR,
            8'h41, CH_STAR, 8'h34, 8'h31, CH_LF,
            8'h00, 8'hFF, CH_STAR, 8'h46, 8'h46, CH_CR,
            8'hAB, CH_STAR, 8'h61, 8'h62, CH_LF,
            8'h78, 8'h79, CH_STAR, 8'h30, 8'h30, CH_CR,
            CH_STAR, 8'h30, CH_LF,
            8'h51, CH_STAR, 8'h35, 8'h47, CH_CR
        };
        int line_no;
        int pick;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (opening[i])
        begin
            send_byte(opening[i]);
        end
        long_hold = 1'b1;
        line_no = 0;
        while (sent_bytes < RUN_BYTES)
        begin
            if (line_no == 8)
            begin
                add_framed(LINE_LIMIT - 4, 1'b0);
                line_q.push_back(CH_CR);
                while (line_q.size() > 0)
                begin
                    send_byte(line_q.pop_front());
                end
            end
            else if (line_no == 30)
            begin
                repeat (LINE_LIMIT)
                begin
                    send_byte(body_byte());
                end
                drive_line(LINE_GOOD);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    drive_line(LINE_GOOD);
                end
                else if (pick < 70)
                begin
                    drive_line(LINE_MISMATCH);
                end
                else if (pick < 78)
                begin
                    drive_line(LINE_NO_STAR);
                end
                else if (pick < 86)
                begin
                    drive_line(LINE_BAD_DIGIT);
                end
                else if (pick < 92)
                begin
                    drive_line(LINE_SHORT);
                end
                else
                begin
                    drive_line(LINE_NOISE);
                end
            end
            line_no++;
        end
        @(negedge clk);
        in_valid = 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("checksummed_line_deframer_core_tb passed");
        end
        else
        begin
            $display("checksummed_line_deframer_core_tb failed");
        end
        $finish;
    end

endmodule
